// File: design/point_set_radial_distance_stats_assert.svh
// Assertion macros shared by the radial distance statistics RTL.
// Plain text macros; no dependencies.
`ifndef POINT_SET_RADIAL_DISTANCE_STATS_ASSERT_SVH
`define POINT_SET_RADIAL_DISTANCE_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/psrd_pkg.sv
// Shared widths, types and codes for the radial distance statistics block.
// No dependencies.
package psrd_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned NUM_SQ     = 3;

  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned RAD_W      = 2 * DIFF_W;
  localparam int unsigned DIST_W     = RAD_W / 2;
  localparam int unsigned SQRT_REM_W = DIST_W + 2;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W      = DIST_W + $clog2(MAX_POINTS);
  localparam int unsigned STEP_W     = $clog2(SUM_W + 1);
  localparam int unsigned SQ_SEL_W   = $clog2(NUM_SQ);

  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = $clog2(4 * NUM_SQ);
  localparam int unsigned REG_IDX_W  = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = REG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } psrd_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } cfg_t;

  typedef struct packed {
    logic                capture;
    logic                sq_en;
    logic [SQ_SEL_W-1:0] sq_sel;
    logic                sq_acc;
    logic                sqrt_step;
    logic                update;
    logic                div_init;
    logic                div_step;
    logic                emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/psrd_if.sv
// Valid/ready channels for point words in and statistics words out.
// Depends on psrd_pkg.
interface psrd_in_if;
  import psrd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      is_last;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output is_last, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input is_last, output ready);
endinterface

interface psrd_out_if;
  import psrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] max_distance;
  logic [DIST_W-1:0] min_distance;
  logic [DIST_W-1:0] mean_distance;

  modport source (output valid, output max_distance, output min_distance,
                  output mean_distance, input ready);
  modport sink (input valid, input max_distance, input min_distance,
                input mean_distance, output ready);
endinterface

// File: design/point_set_radial_distance_stats.sv
// Radial distance statistics: each accepted point word goes through accept,
// three squarings on one shared 25x25 multiplier plus an accumulate, 25 steps of
// the bit-pair square root and one statistics update. A point marked last then
// passes the 35-step divider that forms the mean and the loading of the output
// register. The result sits in an output register, so the next point is taken
// while a result waits; the result after it waits in the statistics registers
// until the previous one is taken. Centre registers sit at APB offsets 0x0, 0x4
// and 0x8 and should be written only while the block is idle.
// Depends on psrd_pkg, psrd_if, psrd_cfg, psrd_ctrl and psrd_dp.
module point_set_radial_distance_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psrd_pkg::APB_AW-1:0]   paddr,
  input  logic [psrd_pkg::APB_DW-1:0]   pwdata,
  output logic [psrd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  psrd_in_if.sink                       pt_i,
  psrd_out_if.source                    res_o
);
  import psrd_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  psrd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign pt_i.ready = in_ready;

  psrd_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .point_x_i (pt_i.point_x),
    .point_y_i (pt_i.point_y),
    .point_z_i (pt_i.point_z),
    .is_last_i (pt_i.is_last),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .res_o     (res_o)
  );

endmodule

// File: design/psrd_cfg.sv
// APB register file holding the reference centre coordinates.
// Depends on psrd_pkg.
module psrd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psrd_pkg::APB_AW-1:0]   paddr,
  input  logic [psrd_pkg::APB_DW-1:0]   pwdata,
  output logic [psrd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output psrd_pkg::cfg_t                cfg_o
);
  import psrd_pkg::*;

  logic                      wr_en;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic signed [COORD_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_X: cx_q <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: cy_q <= pwdata[COORD_W-1:0];
        REG_CENTER_Z: cz_q <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: rd_val = cx_q;
      REG_CENTER_Y: rd_val = cy_q;
      REG_CENTER_Z: rd_val = cz_q;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = APB_DW'(rd_val);

  assign cfg_o.cx = cx_q;
  assign cfg_o.cy = cy_q;
  assign cfg_o.cz = cz_q;

endmodule

// File: design/psrd_dp.sv
// Datapath: shared squarer, bit-pair square root, statistics registers,
// bit-serial divider for the mean and the output word register.
// Depends on psrd_pkg, psrd_if and the assertion macro header.
`include "point_set_radial_distance_stats_assert.svh"

module psrd_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  psrd_pkg::cfg_t                     cfg_i,
  input  logic signed [psrd_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [psrd_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [psrd_pkg::COORD_W-1:0] point_z_i,
  input  logic                               is_last_i,
  input  psrd_pkg::dp_cmd_t                  cmd_i,
  output psrd_pkg::dp_stat_t                 stat_o,
  psrd_out_if.source                         res_o
);
  import psrd_pkg::*;

  // per-point working registers
  logic signed [DIFF_W-1:0]  d_q [NUM_SQ];
  logic                      last_q;
  logic [RAD_W-1:0]          prod_q;
  logic [RAD_W-1:0]          acc_q;
  logic [DIST_W-1:0]         root_q;
  logic [SQRT_REM_W-1:0]     srem_q;

  // set statistics
  logic [DIST_W-1:0]         max_q, min_q;
  logic [SUM_W-1:0]          sum_q;
  logic [CNT_W-1:0]          cnt_q;

  // divider
  logic [SUM_W-1:0]          dq_q;
  logic [CNT_W-1:0]          drem_q;

  // output word
  logic                      out_valid_q;
  logic [DIST_W-1:0]         out_max_q, out_min_q, out_mean_q;

  logic signed [DIFF_W-1:0]  dx, dy, dz, d_sel;
  logic signed [RAD_W-1:0]   prod;
  logic [SQRT_REM_W+1:0]     srem_sh, trial;
  logic                      sq_ge;
  logic [SQRT_REM_W-1:0]     srem_d;
  logic [DIST_W-1:0]         root_d;
  logic                      in_range;
  logic [CNT_W:0]            drem_sh;
  logic                      dv_ge;
  logic [CNT_W-1:0]          drem_d;

  assign dx = DIFF_W'(point_x_i) - DIFF_W'(cfg_i.cx);
  assign dy = DIFF_W'(point_y_i) - DIFF_W'(cfg_i.cy);
  assign dz = DIFF_W'(point_z_i) - DIFF_W'(cfg_i.cz);

  // square of a signed difference is never negative
  assign d_sel = d_q[cmd_i.sq_sel];
  assign prod  = d_sel * d_sel;

  // one result bit per step, radicand consumed two bits at a time from the top
  assign srem_sh = {srem_q, acc_q[RAD_W-1 -: 2]};
  assign trial   = (SQRT_REM_W+2)'({root_q, 2'b01});
  assign sq_ge   = srem_sh >= trial;
  assign srem_d  = sq_ge ? SQRT_REM_W'(srem_sh - trial) : SQRT_REM_W'(srem_sh);
  assign root_d  = {root_q[DIST_W-2:0], sq_ge};

  assign in_range = cnt_q < CNT_W'(MAX_POINTS);

  // restoring division, one quotient bit per step, count never zero here
  assign drem_sh = {drem_q, dq_q[SUM_W-1]};
  assign dv_ge   = drem_sh >= {1'b0, cnt_q};
  assign drem_d  = dv_ge ? CNT_W'(drem_sh - {1'b0, cnt_q}) : CNT_W'(drem_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      min_q       <= '1;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        max_q <= '0;
        min_q <= '1;
        sum_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.update && in_range) begin
        if (root_q > max_q) begin
          max_q <= root_q;
        end
        if (root_q < min_q) begin
          min_q <= root_q;
        end
        sum_q <= sum_q + SUM_W'(root_q);
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      d_q[0] <= dx;
      d_q[1] <= dy;
      d_q[2] <= dz;
      last_q <= is_last_i;
    end
    if (cmd_i.sq_en) begin
      prod_q <= RAD_W'(prod);
    end
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (cmd_i.sq_acc) begin
      acc_q <= acc_q + prod_q;
    end else if (cmd_i.sqrt_step) begin
      acc_q <= acc_q << 2;
    end
    if (cmd_i.capture) begin
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      root_q <= root_d;
      srem_q <= srem_d;
    end
    if (cmd_i.div_init) begin
      dq_q   <= sum_q;
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[SUM_W-2:0], dv_ge};
      drem_q <= drem_d;
    end
    if (cmd_i.emit) begin
      out_max_q  <= max_q;
      out_min_q  <= min_q;
      out_mean_q <= dq_q[DIST_W-1:0];
    end
  end

  assign stat_o.is_last  = last_q;
  assign stat_o.out_free = !out_valid_q || res_o.ready;

  assign res_o.valid         = out_valid_q;
  assign res_o.max_distance  = out_max_q;
  assign res_o.min_distance  = out_min_q;
  assign res_o.mean_distance = out_mean_q;

  `PSRD_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_POINTS), "point count beyond limit")
  `PSRD_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, cmd_i.emit, (cnt_q == '0) && out_valid_q && (max_q == '0), "set not cleared on emit")
  `PSRD_ASSERT_NEXT(a_cnt_inc, clk_i, rst_ni, cmd_i.update && !cmd_i.emit && in_range, cnt_q == $past(cnt_q) + CNT_W'(1), "count missed a point")

endmodule

// File: design/psrd_ctrl.sv
// Sequencer: steps one point word through square, root and update, and the
// last point of a set through the divider and out. Depends on psrd_pkg.
`include "point_set_radial_distance_stats_assert.svh"

module psrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psrd_pkg::dp_stat_t  stat_i,
  output psrd_pkg::dp_cmd_t   cmd_o
);
  import psrd_pkg::*;

  psrd_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q + STEP_W'(1);
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (step_q == STEP_W'(NUM_SQ)) begin
          state_d = ST_SQRT;
          step_d  = '0;
        end
      end
      ST_SQRT: begin
        if (step_q == STEP_W'(DIST_W - 1)) begin
          state_d = ST_UPDATE;
          step_d  = '0;
        end
      end
      ST_UPDATE: begin
        step_d  = '0;
        state_d = stat_i.is_last ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (step_q == STEP_W'(SUM_W)) begin
          state_d = ST_DONE;
          step_d  = '0;
        end
      end
      ST_DONE: begin
        step_d = '0;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SQUARE: begin
        // multiply in steps 0..2, accumulate the registered products in steps 1..3
        cmd_o.sq_en  = step_q < STEP_W'(NUM_SQ);
        cmd_o.sq_sel = cmd_o.sq_en ? step_q[SQ_SEL_W-1:0] : '0;
        cmd_o.sq_acc = step_q != '0;
      end
      ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_DIVIDE: begin
        cmd_o.div_init = step_q == '0;
        cmd_o.div_step = step_q != '0;
      end
      ST_DONE:   cmd_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

  `PSRD_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd_o.emit, stat_i.out_free, "emit into a busy output register")
  `PSRD_ASSERT_IMP(a_one_op, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.capture, cmd_o.sq_en, cmd_o.sqrt_step, cmd_o.update, cmd_o.div_init, cmd_o.div_step, cmd_o.emit}), "overlapping datapath commands")
  `PSRD_ASSERT_NEXT(a_accept_square, clk_i, rst_ni, in_valid_i && in_ready_o, (state_q == ST_SQUARE) && (step_q == '0), "accepted word not sequenced")

endmodule
